// ===== hdl/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types, constants and register codes for the delayed PD servo.
// ----------------------------------------------------------------------------
package dps_pkg;

  // Command delay line
  localparam int MAX_DELAY   = 16;
  localparam int RING_DEPTH  = MAX_DELAY + 1;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int DLY_W       = 5;

  // Data widths
  localparam int POS_W       = 24;
  localparam int GAIN_W      = 16;
  localparam int FORCE_W     = 23;
  localparam int PCT_W       = 8;
  localparam int ERR_W       = POS_W + 1;
  localparam int PROD_W      = ERR_W + GAIN_W + 1;
  localparam int SUM_W       = PROD_W;
  localparam int PD_W        = SUM_W - 8;
  localparam int SCALED_W    = FORCE_W + 7;

  // Stiffness clamp
  localparam int PCT_MIN     = 5;
  localparam int PCT_MAX     = 100;

  // Divide by 100: q = (x * RECIP_K) >> RECIP_SHIFT, exact for x below 2^30
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP_K = 31'd1374389535;

  // Configuration port
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // Register reset values
  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd256;
  localparam logic [GAIN_W-1:0]  KD_RST    = 16'd0;
  localparam logic [FORCE_W-1:0] FORCE_RST = 23'h7FFFFF;
  localparam logic [PCT_W-1:0]   PCT_RST   = 8'd100;
  localparam logic [DLY_W-1:0]   DLY_RST   = 5'd0;
  localparam logic [POS_W-1:0]   LMIN_RST  = 24'h800000;
  localparam logic [POS_W-1:0]   LMAX_RST  = 24'h7FFFFF;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_KP_GAIN       = 3'd0,
    REG_KD_GAIN       = 3'd1,
    REG_MAX_FORCE     = 3'd2,
    REG_STIFFNESS_PCT = 3'd3,
    REG_DELAY_TICKS   = 3'd4,
    REG_LIMIT_MIN     = 3'd5,
    REG_LIMIT_MAX     = 3'd6,
    REG_HINGE_MODE    = 3'd7
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_D,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [GAIN_W-1:0]  kp_gain;
    logic        [GAIN_W-1:0]  kd_gain;
    logic        [FORCE_W-1:0] max_force;
    logic        [PCT_W-1:0]   stiffness_pct;
    logic        [DLY_W-1:0]   delay_ticks;
    logic signed [POS_W-1:0]   limit_min;
    logic signed [POS_W-1:0]   limit_max;
    logic                      hinge_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] command_pos;
    logic signed [POS_W-1:0] measured_pos;
    logic signed [POS_W-1:0] measured_vel;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] drive;
    logic signed [POS_W-1:0] unwrapped_pos;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic mul_p;
    logic mul_d;
    logic scale;
    logic finish;
  } dp_cmd_t;

endpackage

// ===== hdl/dps_regs.sv =====
// ----------------------------------------------------------------------------
// dps_regs
// Configuration register file behind a two-phase bus port.
// ----------------------------------------------------------------------------
module dps_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output dps_pkg::cfg_t                  cfg
);
  import dps_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KP_GAIN:       cfg_nxt.kp_gain       = cfg_pwdata[GAIN_W-1:0];
        REG_KD_GAIN:       cfg_nxt.kd_gain       = cfg_pwdata[GAIN_W-1:0];
        REG_MAX_FORCE:     cfg_nxt.max_force     = cfg_pwdata[FORCE_W-1:0];
        REG_STIFFNESS_PCT: cfg_nxt.stiffness_pct = cfg_pwdata[PCT_W-1:0];
        REG_DELAY_TICKS:   cfg_nxt.delay_ticks   = cfg_pwdata[DLY_W-1:0];
        REG_LIMIT_MIN:     cfg_nxt.limit_min     = signed'(cfg_pwdata[POS_W-1:0]);
        REG_LIMIT_MAX:     cfg_nxt.limit_max     = signed'(cfg_pwdata[POS_W-1:0]);
        REG_HINGE_MODE:    cfg_nxt.hinge_mode    = cfg_pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain       <= KP_RST;
      cfg_r.kd_gain       <= KD_RST;
      cfg_r.max_force     <= FORCE_RST;
      cfg_r.stiffness_pct <= PCT_RST;
      cfg_r.delay_ticks   <= DLY_RST;
      cfg_r.limit_min     <= signed'(LMIN_RST);
      cfg_r.limit_max     <= signed'(LMAX_RST);
      cfg_r.hinge_mode    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_KP_GAIN:       cfg_prdata = CFG_DATA_W'(cfg_r.kp_gain);
      REG_KD_GAIN:       cfg_prdata = CFG_DATA_W'(cfg_r.kd_gain);
      REG_MAX_FORCE:     cfg_prdata = CFG_DATA_W'(cfg_r.max_force);
      REG_STIFFNESS_PCT: cfg_prdata = CFG_DATA_W'(cfg_r.stiffness_pct);
      REG_DELAY_TICKS:   cfg_prdata = CFG_DATA_W'(cfg_r.delay_ticks);
      REG_LIMIT_MIN:     cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.limit_min));
      REG_LIMIT_MAX:     cfg_prdata = CFG_DATA_W'(unsigned'(cfg_r.limit_max));
      REG_HINGE_MODE:    cfg_prdata = CFG_DATA_W'(cfg_r.hinge_mode);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dps_ctrl.sv =====
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer for one servo tick: prepare, two gain products, scale, deliver.
// ----------------------------------------------------------------------------
module dps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dps_pkg::dp_cmd_t cmd
);
  import dps_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("output valid without a finished item");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PREP))
    else $error("accepted item not started");
`endif

endmodule

// ===== hdl/dps_dp.sv =====
// ----------------------------------------------------------------------------
// dps_dp
// Datapath: command clamp, delay ring, unwrap, shared gain multiplier,
// saturation and stiffness scaling.
// ----------------------------------------------------------------------------
module dps_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dps_pkg::cfg_t      cfg,
  input  dps_pkg::dp_cmd_t   cmd,
  input  dps_pkg::in_item_t  in_data,
  output dps_pkg::out_item_t out_data
);
  import dps_pkg::*;

  // Latched item
  logic signed [POS_W-1:0]  cmd_r;
  logic signed [POS_W-1:0]  meas_r;
  logic signed [POS_W-1:0]  vel_r;

  // Delay ring
  logic signed [POS_W-1:0]  store_r [RING_DEPTH];
  logic [RING_DEPTH-1:0]    valid_r;
  logic signed [POS_W-1:0]  first_r;
  logic [PTR_W-1:0]         wp_r;
  logic [PTR_W-1:0]         wp_nxt;
  logic                     started_r;
  logic signed [POS_W-1:0]  prev_r;

  // Working registers
  logic signed [POS_W-1:0]  cur_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SCALED_W-1:0]      smag_r;
  logic                     neg_r;
  out_item_t                out_r;

  logic signed [POS_W-1:0]  cmd_clamp;
  logic [PTR_W-1:0]         dly;
  logic [PTR_W:0]           rp_wide;
  logic [PTR_W-1:0]         rp;
  logic signed [POS_W-1:0]  target;
  logic [15:0]              delta;
  logic signed [POS_W:0]    unwrap_sum;
  logic signed [POS_W-1:0]  cur;

  logic signed [ERR_W-1:0]  mul_a;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [PD_W-1:0]   pd;
  logic signed [PD_W-1:0]   lim_hi;
  logic signed [PD_W-1:0]   lim_lo;
  logic signed [PD_W-1:0]   sat;
  logic [FORCE_W-1:0]       mag;
  logic [6:0]               pct;
  logic [SCALED_W+RECIP_W-1:0] recip_prod;
  logic [FORCE_W-1:0]       quot;

  // Clamp command: upper limit first
  always_comb begin
    if (cmd_r > cfg.limit_max) begin
      cmd_clamp = cfg.limit_max;
    end else if (cmd_r < cfg.limit_min) begin
      cmd_clamp = cfg.limit_min;
    end else begin
      cmd_clamp = cmd_r;
    end
  end

  // Read pointer delay entries behind the newest one
  always_comb begin
    if (int'(cfg.delay_ticks) > MAX_DELAY) begin
      dly = PTR_W'(MAX_DELAY);
    end else begin
      dly = PTR_W'(cfg.delay_ticks);
    end
    if (wp_r >= dly) begin
      rp_wide = {1'b0, wp_r} - {1'b0, dly};
    end else begin
      rp_wide = {1'b0, wp_r} + (PTR_W+1)'(RING_DEPTH) - {1'b0, dly};
    end
    rp = rp_wide[PTR_W-1:0];
  end

  // Select target; unwritten entries hold the first measured position
  always_comb begin
    if (dly == '0) begin
      target = cmd_clamp;
    end else if (valid_r[rp]) begin
      target = store_r[rp];
    end else if (started_r) begin
      target = first_r;
    end else begin
      target = meas_r;
    end
  end

  // Unwrap the hinge angle against the previous position, saturating (hinge mode only)
  always_comb begin
    delta      = meas_r[15:0] - prev_r[15:0];
    unwrap_sum = (POS_W+1)'(prev_r) + (POS_W+1)'(signed'(delta));
    if (!cfg.hinge_mode) begin
      cur = meas_r;
    end else if (unwrap_sum[POS_W] != unwrap_sum[POS_W-1]) begin
      cur = unwrap_sum[POS_W] ? signed'(LMIN_RST) : signed'(LMAX_RST);
    end else begin
      cur = unwrap_sum[POS_W-1:0];
    end
  end

  assign wp_nxt = (int'(wp_r) == RING_DEPTH - 1) ? '0 : wp_r + 1'b1;

  // Shared gain multiplier
  always_comb begin
    if (cmd.mul_d) begin
      mul_a = ERR_W'(vel_r);
      mul_b = signed'({1'b0, cfg.kd_gain});
    end else begin
      mul_a = err_r;
      mul_b = signed'({1'b0, cfg.kp_gain});
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Floor shift, saturate, take magnitude and stiffness percent
  always_comb begin
    pd     = PD_W'(sum_r >>> 8);
    lim_hi = signed'(PD_W'(cfg.max_force));
    lim_lo = -lim_hi;
    if (pd > lim_hi) begin
      sat = lim_hi;
    end else if (pd < lim_lo) begin
      sat = lim_lo;
    end else begin
      sat = pd;
    end
    mag = sat[PD_W-1] ? FORCE_W'(-sat) : FORCE_W'(sat);
    if (cfg.stiffness_pct < PCT_W'(PCT_MIN)) begin
      pct = 7'(PCT_MIN);
    end else if (cfg.stiffness_pct > PCT_W'(PCT_MAX)) begin
      pct = 7'(PCT_MAX);
    end else begin
      pct = cfg.stiffness_pct[6:0];
    end
  end

  // Divide by 100 through the reciprocal, truncating toward zero
  always_comb begin
    recip_prod = (SCALED_W+RECIP_W)'(smag_r) * (SCALED_W+RECIP_W)'(RECIP_K);
    quot       = FORCE_W'(recip_prod >> RECIP_SHIFT);
  end

  // Control state of the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      wp_r      <= '0;
      started_r <= 1'b0;
      prev_r    <= '0;
    end else if (cmd.prep) begin
      valid_r[wp_r] <= 1'b1;
      wp_r          <= wp_nxt;
      started_r     <= 1'b1;
      prev_r        <= cur;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_data.command_pos;
      meas_r <= in_data.measured_pos;
      vel_r  <= in_data.measured_vel;
    end
    if (cmd.prep) begin
      store_r[wp_r] <= cmd_clamp;
      if (!started_r) begin
        first_r <= meas_r;
      end
      cur_r <= cur;
      err_r <= ERR_W'(target) - ERR_W'(cur);
    end
    if (cmd.mul_p) begin
      acc_r <= prod;
    end
    if (cmd.mul_d) begin
      sum_r <= acc_r - prod;
    end
    if (cmd.scale) begin
      smag_r <= SCALED_W'(mag) * SCALED_W'(pct);
      neg_r  <= sat[PD_W-1];
    end
    if (cmd.finish) begin
      out_r.drive         <= neg_r ? -POS_W'(quot) : POS_W'(quot);
      out_r.unwrapped_pos <= cur_r;
    end
  end

  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(wp_r) < RING_DEPTH)
    else $error("write pointer beyond ring");

  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped without reset");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep |=> valid_r[$past(wp_r)])
    else $error("written ring entry not marked valid");
`endif

endmodule

// ===== hdl/delayed_pd_servo.sv =====
// An accepted item runs the controller states prepare, kp product, kd product,
// scale and deliver around the one shared gain multiplier; deliver waits while the
// output register is still held. A new item is accepted only once the sequence is idle.
// Reset: rst_n is synchronous, active low; it restores register defaults and
// empties the command delay line, which takes the first measured position.
// ----------------------------------------------------------------------------
// delayed_pd_servo
// Top level: PD position servo with delayed command and hinge unwrapping.
// ----------------------------------------------------------------------------
module delayed_pd_servo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dps_pkg::out_item_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import dps_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // Configuration registers
  dps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Tick sequencer
  dps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and delay line
  dps_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
